@@ rtl/rgb_channel_split_unit_assert.svh @@
// assertion macros used by the checker file
`ifndef RGB_CHANNEL_SPLIT_UNIT_ASSERT_SVH
`define RGB_CHANNEL_SPLIT_UNIT_ASSERT_SVH

// clocked assertion, off while reset is asserted
`define RCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must never be seen
`define RCS_ASSERT_NEVER(lbl, expr, msg) \
  `RCS_ASSERT(lbl, !(expr), msg)

`endif

@@ rtl/rcs_pkg.sv @@
// shared constants, types and command/status structs of the channel split unit
package rcs_pkg;

  localparam int MaxShift = 31;
  localparam int CfgW     = 5;
  localparam int DW       = $clog2(MaxShift + 1);
  localparam int PosMax   = 2 * MaxShift;
  localparam int PosW     = $clog2(PosMax + 1);
  localparam int WinDepth = 2 ** PosW;
  localparam int AddrW    = PosW;
  localparam int ChanW    = 8;
  localparam int PixW     = 3 * ChanW;

  localparam logic [CfgW-1:0] ShiftReset = CfgW'(25);

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic             row_end;
    logic             last_of_run;
  } result_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic emit;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic need_out;
    logic k_zero;
    logic flush;
    logic out_free;
  } status_t;

endpackage

@@ rtl/rcs_pix_in_if.sv @@
// input pixel channel: valid/ready plus one pixel and its end-of-row mark
interface rcs_pix_in_if;
  logic                      valid;
  logic                      ready;
  logic [rcs_pkg::ChanW-1:0] red_in;
  logic [rcs_pkg::ChanW-1:0] green_in;
  logic [rcs_pkg::ChanW-1:0] blue_in;
  logic                      end_of_row;

  modport source (output valid, red_in, green_in, blue_in, end_of_row, input ready);
  modport sink (input valid, red_in, green_in, blue_in, end_of_row, output ready);
endinterface

@@ rtl/rcs_pix_out_if.sv @@
// output pixel channel: valid/ready plus one shifted pixel and its marks
interface rcs_pix_out_if;
  logic                      valid;
  logic                      ready;
  logic [rcs_pkg::ChanW-1:0] red_out;
  logic [rcs_pkg::ChanW-1:0] green_out;
  logic [rcs_pkg::ChanW-1:0] blue_out;
  logic                      row_end;
  logic                      last_of_run;

  modport source (output valid, red_out, green_out, blue_out, row_end, last_of_run,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, row_end, last_of_run,
                output ready);
endinterface

@@ rtl/rcs_ram.sv @@
// generic ram: one write port, two registered read ports
module rcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ rtl/rcs_ctrl.sv @@
// sequencer: accept a pixel, then read and emit each result in turn
module rcs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rcs_pkg::status_t status_i,
  output rcs_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0] state_q, state_d;
  logic       done;

  // a run ends on an ordinary pixel's single result or at position zero of a flush
  assign done = !status_i.flush || status_i.k_zero;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.need_out) begin
          state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StEmit;
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.step = !done;
          state_d    = done ? StIdle : StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/rcs_datapath.sv @@
// datapath: row position, window pointers, result selection and output register
module rcs_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rcs_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic [rcs_pkg::ChanW-1:0] red_i,
  input  logic [rcs_pkg::ChanW-1:0] green_i,
  input  logic [rcs_pkg::ChanW-1:0] blue_i,
  input  logic                      eor_i,
  input  rcs_pkg::cmd_t             cmd_i,
  output rcs_pkg::status_t          status_o,
  output logic                      ram_we_o,
  output logic [rcs_pkg::AddrW-1:0] ram_waddr_o,
  output logic [rcs_pkg::PixW-1:0]  ram_wdata_o,
  output logic                      ram_re_o,
  output logic [rcs_pkg::AddrW-1:0] ram_raddr_g_o,
  output logic [rcs_pkg::AddrW-1:0] ram_raddr_r_o,
  input  logic [rcs_pkg::PixW-1:0]  ram_rdata_g_i,
  input  logic [rcs_pkg::PixW-1:0]  ram_rdata_r_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output rcs_pkg::result_t          out_o
);

  logic [rcs_pkg::CfgW-1:0]  shift_q;
  logic [rcs_pkg::PosW-1:0]  pos_q, pos_d;
  logic [rcs_pkg::AddrW-1:0] wr_ptr_q;
  logic [rcs_pkg::AddrW-1:0] newest_q;
  logic [rcs_pkg::ChanW-1:0] first_red_q;
  logic [rcs_pkg::ChanW-1:0] blue_q;
  logic                      eor_q;
  logic [rcs_pkg::PosW-1:0]  p_q;
  logic [rcs_pkg::DW-1:0]    d_q;
  logic [rcs_pkg::DW-1:0]    k_q;
  logic                      out_valid_q;
  rcs_pkg::result_t          out_q;

  logic [rcs_pkg::DW-1:0]    d_eff;
  logic [rcs_pkg::DW-1:0]    k_start;
  logic [rcs_pkg::PosW-1:0]  red_back;
  logic                      k_zero;
  rcs_pkg::result_t          res;

  always_comb begin
    if (int'(shift_q) > rcs_pkg::MaxShift) begin
      d_eff = rcs_pkg::DW'(rcs_pkg::MaxShift);
    end else begin
      d_eff = rcs_pkg::DW'(shift_q);
    end
  end

  // flush starts at min(p, d) places back, an ordinary pixel at d
  assign k_start = (eor_i && (pos_q < rcs_pkg::PosW'(d_eff))) ? rcs_pkg::DW'(pos_q) : d_eff;
  assign red_back = rcs_pkg::PosW'(k_q) + rcs_pkg::PosW'(d_q);
  assign k_zero = (k_q == '0);

  always_comb begin
    if (eor_i) begin
      pos_d = '0;
    end else if (pos_q < rcs_pkg::PosW'(rcs_pkg::PosMax)) begin
      pos_d = pos_q + rcs_pkg::PosW'(1);
    end else begin
      pos_d = pos_q;
    end
  end

  assign status_o.need_out = eor_i || (pos_q >= rcs_pkg::PosW'(d_eff));
  assign status_o.k_zero   = k_zero;
  assign status_o.flush    = eor_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign ram_we_o      = cmd_i.accept;
  assign ram_waddr_o   = wr_ptr_q;
  assign ram_wdata_o   = {red_i, green_i, blue_i};
  assign ram_re_o      = cmd_i.rd_en;
  assign ram_raddr_g_o = newest_q - rcs_pkg::AddrW'(k_q);
  assign ram_raddr_r_o = newest_q - rcs_pkg::AddrW'(red_back);

  always_comb begin
    // red falls back to the row's first pixel when its source lies before the row
    if (p_q >= red_back) begin
      res.red_out = ram_rdata_r_i[rcs_pkg::PixW-1 -: rcs_pkg::ChanW];
    end else begin
      res.red_out = first_red_q;
    end
    res.green_out   = ram_rdata_g_i[2*rcs_pkg::ChanW-1 -: rcs_pkg::ChanW];
    res.blue_out    = blue_q;
    res.row_end     = eor_q && k_zero;
    res.last_of_run = !eor_q || k_zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= rcs_pkg::ShiftReset;
      pos_q       <= '0;
      wr_ptr_q    <= '0;
      first_red_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        shift_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        pos_q    <= pos_d;
        wr_ptr_q <= wr_ptr_q + rcs_pkg::AddrW'(1);
        if (pos_q == '0) begin
          first_red_q <= red_i;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      newest_q <= wr_ptr_q;
      blue_q   <= blue_i;
      eor_q    <= eor_i;
      p_q      <= pos_q;
      d_q      <= d_eff;
      k_q      <= k_start;
    end else if (cmd_i.step) begin
      k_q <= k_q - rcs_pkg::DW'(1);
    end
    if (cmd_i.emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ rtl/rgb_channel_split_unit.sv @@
// top level of the rgb channel split (chromatic aberration) unit
// usage:
//   in_i takes one pixel per beat in raster order, end_of_row set on the last
//   pixel of each row. out_o gives pixels whose red comes from shift_distance
//   places left and blue from shift_distance places right, clamped to the row.
//   cfg_we_i/cfg_wdata_i write shift_distance (reset value 25), only when idle.
// sequencing:
//   a pixel that yields no result (position below the shift, no end of row)
//   is taken in the idle state alone. every result takes a window read state,
//   then an output load state, so an ordinary pixel passes idle, read and emit,
//   and an end-of-row pixel with n flushed results passes idle and n read/emit
//   pairs. the first result is loaded into the output register in its emit
//   state. the unit works on one result at a time, one window ram read each.
// reset:
//   asynchronous, active low. row position, first red, write pointer and the
//   output valid clear at once; the window ram is not cleared, only entries of
//   the current row are ever used.
// stall:
//   a result waits in the output register while out_o.ready is low; the
//   sequencer holds the next result, and with it the input, until it is free.
module rgb_channel_split_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [rcs_pkg::CfgW-1:0] cfg_wdata_i,
  rcs_pix_in_if.sink               in_i,
  rcs_pix_out_if.source            out_o
);

  rcs_pkg::cmd_t    cmd;
  rcs_pkg::status_t status;
  rcs_pkg::result_t result;

  // window ram hookup
  logic                      ram_we;
  logic [rcs_pkg::AddrW-1:0] ram_waddr;
  logic [rcs_pkg::PixW-1:0]  ram_wdata;
  logic                      ram_re;
  logic [rcs_pkg::AddrW-1:0] ram_raddr_g;
  logic [rcs_pkg::AddrW-1:0] ram_raddr_r;
  logic [rcs_pkg::PixW-1:0]  ram_rdata_g;
  logic [rcs_pkg::PixW-1:0]  ram_rdata_r;
  logic                      out_valid;
  logic                      in_ready;

  rcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rcs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .red_i         (in_i.red_in),
    .green_i       (in_i.green_in),
    .blue_i        (in_i.blue_in),
    .eor_i         (in_i.end_of_row),
    .cmd_i         (cmd),
    .status_o      (status),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_g_o (ram_raddr_g),
    .ram_raddr_r_o (ram_raddr_r),
    .ram_rdata_g_i (ram_rdata_g),
    .ram_rdata_r_i (ram_rdata_r),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_valid),
    .out_o         (result)
  );

  // circular pixel window, each pixel written at the write pointer
  rcs_ram #(
    .Width (rcs_pkg::PixW),
    .Depth (rcs_pkg::WinDepth)
  ) u_window (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_a_i (ram_raddr_g),
    .raddr_b_i (ram_raddr_r),
    .rdata_a_o (ram_rdata_g),
    .rdata_b_o (ram_rdata_r)
  );

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid;
  assign out_o.red_out     = result.red_out;
  assign out_o.green_out   = result.green_out;
  assign out_o.blue_out    = result.blue_out;
  assign out_o.row_end     = result.row_end;
  assign out_o.last_of_run = result.last_of_run;

endmodule

@@ rtl/rcs_checker.sv @@
// port-level checker for the channel split unit, bound to the top level
`include "rgb_channel_split_unit_assert.svh"

module rcs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_end_of_row_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [rcs_pkg::ChanW-1:0] out_red_i,
  input logic [rcs_pkg::ChanW-1:0] out_green_i,
  input logic [rcs_pkg::ChanW-1:0] out_blue_i,
  input logic                      out_row_end_i,
  input logic                      out_last_of_run_i
);

  // stalled result beat keeps its payload
  `RCS_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_red_i) && $stable(out_green_i) && $stable(out_blue_i) && $stable(out_row_end_i) && $stable(out_last_of_run_i), "stalled result beat changed")

  // an end-of-row pixel always starts a flush, so no pixel is taken next cycle
  `RCS_ASSERT(a_flush_busy, in_valid_i && in_ready_i && in_end_of_row_i |=> !in_ready_i, "pixel taken during row flush")

  // the row end is always the last result of its run
  `RCS_ASSERT_NEVER(a_row_end_last, out_valid_i && out_row_end_i && !out_last_of_run_i, "row end without last of run")

  // a window read comes first, so no result loads right behind an input beat
  `RCS_ASSERT(a_read_gap, in_valid_i && in_ready_i |-> ##2 !$rose(out_valid_i), "result loaded before window read")

endmodule

bind rgb_channel_split_unit rcs_checker u_rcs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_end_of_row_i   (in_i.end_of_row),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_red_i         (out_o.red_out),
  .out_green_i       (out_o.green_out),
  .out_blue_i        (out_o.blue_out),
  .out_row_end_i     (out_o.row_end),
  .out_last_of_run_i (out_o.last_of_run)
);

@@ dv/testbench.sv @@
// self-checking testbench for the rgb channel split unit: predicted vs observed pixel beats
module testbench;

  import rcs_pkg::*;

  // the window needs 2*MaxShift+1 pixels, the oldest read sits 2*MaxShift back
  localparam int HistDepth  = 2 * MaxShift + 1;
  localparam int IdlePct    = 18;
  localparam int QuietLimit = 4000;
  localparam int DrainWait  = 8;
  localparam int RandItems  = 200;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             eor;
  } pixel_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // testbench-owned copies of every block input, known from time zero
  logic             in_valid  = 1'b0;
  logic [ChanW-1:0] in_red    = '0;
  logic [ChanW-1:0] in_green  = '0;
  logic [ChanW-1:0] in_blue   = '0;
  logic             in_eor    = 1'b0;
  logic             out_ready = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CfgW-1:0]  cfg_wdata = '0;

  rcs_pix_in_if  pix_in ();
  rcs_pix_out_if pix_out ();

  assign pix_in.valid      = in_valid;
  assign pix_in.red_in     = in_red;
  assign pix_in.green_in   = in_green;
  assign pix_in.blue_in    = in_blue;
  assign pix_in.end_of_row = in_eor;
  assign pix_out.ready     = out_ready;

  rgb_channel_split_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (pix_in),
    .out_o       (pix_out)
  );

  // pixels waiting for the driver, and shifted pixels still owed by the block
  pixel_t  pending_pixels[$];
  result_t due_pixels[$];

  // shadow state of the channel shift
  logic [PixW-1:0]  pixel_hist[HistDepth];
  logic [ChanW-1:0] first_red;
  int               row_pos;
  int               shift_cfg;

  // no idling on either side while this is set
  bit calm;

  int mismatches;
  int pixels_in;
  int pixels_out;
  int rows_sent;
  int quiet_cycles;

  // red for the output k places behind the newest pixel at row position p,
  // clamped to the first red of the row when the source lies left of it
  function automatic logic [ChanW-1:0] clamped_red(int p, int k, int d);
    if (p >= k + d && k + d < HistDepth) return pixel_hist[k + d][PixW-1 -: ChanW];
    return first_red;
  endfunction

  // shift the new pixel into the history and queue every output it releases
  task automatic predict_shifted_pixels(input pixel_t px);
    int      d;
    int      p;
    int      k;
    int      i;
    result_t res;
    d = (shift_cfg < MaxShift) ? shift_cfg : MaxShift;
    p = row_pos;
    for (i = HistDepth - 1; i > 0; i--) pixel_hist[i] = pixel_hist[i - 1];
    pixel_hist[0] = {px.red, px.green, px.blue};
    if (p == 0) first_red = px.red;
    if (!px.eor) begin
      // ordinary pixel: releases the position d places back, once it exists
      if (p >= d) begin
        res.red_out     = clamped_red(p, d, d);
        res.green_out   = pixel_hist[d][ChanW +: ChanW];
        res.blue_out    = px.blue;
        res.row_end     = 1'b0;
        res.last_of_run = 1'b1;
        due_pixels.push_back(res);
      end
      // position saturates; every needed offset stays within the window
      if (row_pos < PosMax) row_pos++;
    end else begin
      // end of row: flush the remaining positions, blue clamped to this pixel
      k = (p < d) ? p : d;
      forever begin
        res.red_out     = clamped_red(p, k, d);
        res.green_out   = pixel_hist[k][ChanW +: ChanW];
        res.blue_out    = px.blue;
        res.row_end     = (k == 0);
        res.last_of_run = (k == 0);
        due_pixels.push_back(res);
        if (k == 0) break;
        k--;
      end
      row_pos = 0;
    end
  endtask

  // clock and the single reset pulse
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // input driver: holds a beat until it is taken, idles at random between beats
  always @(posedge clk_i) begin : pixel_driver
    pixel_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && pix_in.ready) begin
        predict_shifted_pixels('{red: in_red, green: in_green, blue: in_blue, eor: in_eor});
        pixels_in++;
      end
      if (!in_valid || pix_in.ready) begin
        if (pending_pixels.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
          nxt = pending_pixels.pop_front();
          in_valid <= 1'b1;
          in_red   <= nxt.red;
          in_green <= nxt.green;
          in_blue  <= nxt.blue;
          in_eor   <= nxt.eor;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: random back-pressure, every beat checked against the oldest due pixel
  always @(posedge clk_i) begin : pixel_monitor
    result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (pix_out.valid && out_ready) begin
        pixels_out++;
        if (due_pixels.size() == 0) begin
          $error("unexpected output beat: red %0d green %0d blue %0d", pix_out.red_out,
                 pix_out.green_out, pix_out.blue_out);
          mismatches++;
        end else begin
          want = due_pixels.pop_front();
          if (pix_out.red_out !== want.red_out) begin
            $error("red_out mismatch: expected %0d, got %0d", want.red_out, pix_out.red_out);
            mismatches++;
          end
          if (pix_out.green_out !== want.green_out) begin
            $error("green_out mismatch: expected %0d, got %0d", want.green_out,
                   pix_out.green_out);
            mismatches++;
          end
          if (pix_out.blue_out !== want.blue_out) begin
            $error("blue_out mismatch: expected %0d, got %0d", want.blue_out,
                   pix_out.blue_out);
            mismatches++;
          end
          if (pix_out.row_end !== want.row_end) begin
            $error("row_end mismatch: expected %0b, got %0b", want.row_end, pix_out.row_end);
            mismatches++;
          end
          if (pix_out.last_of_run !== want.last_of_run) begin
            $error("last_of_run mismatch: expected %0b, got %0b", want.last_of_run,
                   pix_out.last_of_run);
            mismatches++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  // watchdog: too long without any beat on either channel means a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && pix_in.ready) || (pix_out.valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("CHECKS FAILED");
        $display("watchdog: no beat for %0d cycles, %0d pixels still due", quiet_cycles,
                 due_pixels.size());
        $finish;
      end
    end
  end

  task automatic push_pixel(input int r, input int g, input int b, input bit eor);
    pending_pixels.push_back('{red: ChanW'(r), green: ChanW'(g), blue: ChanW'(b), eor: eor});
    if (eor) rows_sent++;
  endtask

  // n random pixels; the last one closes the row when asked
  task automatic push_row(input int n, input bit close_row);
    int i;
    for (i = 0; i < n; i++) begin
      push_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                 close_row && (i == n - 1));
    end
  endtask

  // sender pauses until every due pixel is out, then the block gets time to settle,
  // since a pixel below the shift leaves no output behind to wait for
  task automatic wait_drained();
    while (pending_pixels.size() != 0 || in_valid || due_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_shift(input int shift_dist);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= CfgW'(shift_dist);
    shift_cfg = shift_dist;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int  phase_items;
    int  len;
    int  d;
    int  pick;
    int  i;
    bit  open_row;
    bit  calm_done;
    for (i = 0; i < HistDepth; i++) pixel_hist[i] = '0;
    first_red  = '0;
    row_pos    = 0;
    shift_cfg  = int'(ShiftReset);
    calm       = 1'b0;
    calm_done  = 1'b0;
    mismatches = 0;
    pixels_in  = 0;
    pixels_out = 0;
    rows_sent  = 0;
    quiet_cycles = 0;
    open_row   = 1'b0;

    @(posedge clk_i iff rst_ni);

    // directed: reset shift, single-pixel row and a short row under the shift
    push_pixel(255, 0, 255, 1'b1);
    push_pixel(0, 255, 0, 1'b0);
    push_pixel(255, 255, 255, 1'b0);
    push_pixel(0, 0, 0, 1'b1);

    // zero shift: every pixel maps onto itself
    write_shift(0);
    push_pixel(18, 52, 200, 1'b0);
    push_pixel(77, 1, 254, 1'b1);

    // shift raised and then lowered in the middle of one row
    write_shift(2);
    push_row(4, 1'b0);
    write_shift(5);
    push_row(3, 1'b0);
    write_shift(1);
    push_row(2, 1'b1);

    // widest shift on a short row: the whole row comes out in the flush
    write_shift(MaxShift);
    push_row(5, 1'b1);

    // random phases, each with its own shift; some leave a row open across the write
    while (pixels_in + pending_pixels.size() < RandItems) begin
      pick = $urandom_range(9);
      if (pick < 2)      d = 0;
      else if (pick < 4) d = MaxShift;
      else if (pick < 5) d = 1;
      else               d = $urandom_range(MaxShift);
      write_shift(d);
      // one whole phase past the first hundred pixels runs with both sides always ready
      calm = (pixels_in >= 100) && !calm_done;
      if (calm) calm_done = 1'b1;
      phase_items = 0;
      while (phase_items < 40) begin
        // mostly short rows around the shift, now and then a row past saturation
        if ($urandom_range(9) == 0) len = $urandom_range(PosMax + 1, PosMax + 20);
        else                        len = $urandom_range(1, 2 * d + 3);
        open_row = (phase_items + len >= 40) && ($urandom_range(1) == 1);
        push_row(len, !open_row);
        phase_items += len;
      end
    end
    // close whatever row is still open
    push_row(1 + $urandom_range(3), 1'b1);
    calm = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("covered %0d pixels in %0d closed rows, %0d shifted pixels checked,",
             pixels_in, rows_sent, pixels_out);
    $display("shifts from 0 to %0d, mid-row shift changes, saturated rows, back-pressure",
             MaxShift);
    if (mismatches == 0 && due_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rcs_pkg.sv
rtl/rcs_pix_in_if.sv
rtl/rcs_pix_out_if.sv
rtl/rcs_ram.sv
rtl/rcs_ctrl.sv
rtl/rcs_datapath.sv
rtl/rgb_channel_split_unit.sv
rtl/rcs_checker.sv
dv/testbench.sv
